@@ design/ghht_pkg.sv @@
// ghht_pkg: shared types and constants for the generational handle hash table
// used by ghht_ctrl, ghht_dp and generational_handle_hash_table_top; no dependencies
package ghht_pkg;

  localparam int KEY_W      = 64;
  localparam int GEN_W      = 32;
  localparam int SLOT_NUM_W = 9;
  localparam int STATUS_W   = 3;

  // multiplicative mix constant of the hash
  localparam logic [31:0] HASH_MUL = 32'h9E37_79B9;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_SWEEP   = 2'd1,
    OP_CHECK   = 2'd2
  } ghht_op_t;

  typedef enum logic [2:0] {
    STATUS_FOUND    = 3'd0,
    STATUS_INSERTED = 3'd1,
    STATUS_NULL_KEY = 3'd2,
    STATUS_FULL     = 3'd3,
    STATUS_LIVE     = 3'd4,
    STATUS_NOT_LIVE = 3'd5
  } ghht_status_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_CHECK_RD,
    ST_CHECK_CMP,
    ST_EMIT
  } ghht_state_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_PROBE,
    RD_CHECK,
    RD_SCAN
  } ghht_rd_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_CLEAR,
    WR_TOUCH,
    WR_INSERT
  } ghht_wr_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_FOUND,
    RES_INSERTED,
    RES_NULL,
    RES_FULL,
    RES_SWEPT,
    RES_CHECK
  } ghht_res_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [KEY_W-1:0]      key;
    logic [SLOT_NUM_W-1:0] handle_slot;
    logic [GEN_W-1:0]      handle_generation;
  } ghht_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_NUM_W-1:0] slot_number;
    logic [GEN_W-1:0]      slot_generation;
    logic [SLOT_NUM_W-1:0] occupied_count;
  } ghht_out_t;

  // one table entry: tagged key (zero when empty), generation, touched mark
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [GEN_W-1:0] gen;
    logic             touched;
  } ghht_slot_t;

  typedef struct packed {
    logic      load_in;
    logic      hash_en;
    logic      probe_step;
    logic      scan_inc;
    logic      out_load;
    ghht_rd_t  rd_kind;
    ghht_wr_t  wr_kind;
    ghht_res_t res_kind;
  } ghht_cmd_t;

  typedef struct packed {
    logic hit;
    logic empty;
    logic load_full;
    logic probe_last;
    logic scan_last;
    logic out_free;
  } ghht_sts_t;

endpackage

@@ design/generational_handle_hash_table_top.sv @@
// acquire: hash, then a read and a compare for each slot probed
// check: a read and a compare; null key: straight to the result; sweep: one slot read per cycle
// one transaction in flight at a time; a finished result may wait in the output register
// reset: synchronous active low; a clearing pass then zeroes every slot,
// with in_stall high until it ends
module generational_handle_hash_table_top
  import ghht_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ghht_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output ghht_out_t out_data
);

  // command and status between the sequencer and the datapath
  ghht_cmd_t cmd;
  ghht_sts_t sts;

  // sequencer: one state per step of a transaction, plus the clearing pass
  ghht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: slot memory (key, generation, touched mark), hash multiplier,
  // probe and scan counters, live count and the output register
  ghht_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // any defined op keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_data.op == OP_ACQUIRE || in_data.op == OP_SWEEP ||
     in_data.op == OP_CHECK)) |=> in_stall)
    else $error("block idle right after accepting a transaction");

  // a new result only comes out of a busy sequencer
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in progress");

  // sweep, check, null and full results carry no handle
  a_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == STATUS_NULL_KEY || out_data.status == STATUS_FULL ||
     out_data.status == STATUS_LIVE || out_data.status == STATUS_NOT_LIVE))
    |-> (out_data.slot_number == '0 && out_data.slot_generation == '0))
    else $error("handle fields set on a result without a handle");

endmodule

@@ design/ghht_ctrl.sv @@
// ghht_ctrl: sequencer for acquire, sweep and check transactions
// depends on ghht_pkg; drives ghht_dp through ghht_cmd_t
module ghht_ctrl
  import ghht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  ghht_in_t  in_data,
  output logic      in_stall,
  input  ghht_sts_t sts,
  output ghht_cmd_t cmd
);

  ghht_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_kind  = WR_CLEAR;
        cmd.scan_inc = 1'b1;
        if (sts.scan_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          unique case (in_data.op)
            OP_ACQUIRE: begin
              if (in_data.key == '0) begin
                cmd.res_kind = RES_NULL;
                state_nxt    = ST_EMIT;
              end else begin
                state_nxt = ST_HASH;
              end
            end
            OP_SWEEP: state_nxt = ST_SWEEP;
            OP_CHECK: state_nxt = ST_CHECK_RD;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_HASH: begin
        cmd.hash_en = 1'b1;
        state_nxt   = ST_PROBE_RD;
      end
      ST_PROBE_RD: begin
        cmd.rd_kind = RD_PROBE;
        state_nxt   = ST_PROBE_CMP;
      end
      ST_PROBE_CMP: begin
        if (sts.hit) begin
          cmd.wr_kind  = WR_TOUCH;
          cmd.res_kind = RES_FOUND;
          state_nxt    = ST_EMIT;
        end else if (sts.empty) begin
          if (sts.load_full) begin
            cmd.res_kind = RES_FULL;
          end else begin
            cmd.wr_kind  = WR_INSERT;
            cmd.res_kind = RES_INSERTED;
          end
          state_nxt = ST_EMIT;
        end else if (sts.probe_last) begin
          cmd.res_kind = RES_FULL;
          state_nxt    = ST_EMIT;
        end else begin
          cmd.probe_step = 1'b1;
          state_nxt      = ST_PROBE_RD;
        end
      end
      ST_SWEEP: begin
        cmd.rd_kind  = RD_SCAN;
        cmd.scan_inc = 1'b1;
        if (sts.scan_last) state_nxt = ST_SWEEP_END;
      end
      ST_SWEEP_END: begin
        // last slot writes back this cycle
        cmd.res_kind = RES_SWEPT;
        state_nxt    = ST_EMIT;
      end
      ST_CHECK_RD: begin
        cmd.rd_kind = RD_CHECK;
        state_nxt   = ST_CHECK_CMP;
      end
      ST_CHECK_CMP: begin
        cmd.res_kind = RES_CHECK;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

@@ design/ghht_dp.sv @@
// ghht_dp: slot memory, hash, probe and scan counters, live count, result register
// depends on ghht_pkg; controlled by ghht_ctrl
module ghht_dp
  import ghht_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ghht_in_t  in_data,
  input  ghht_cmd_t cmd,
  output ghht_sts_t sts,
  output logic      out_valid,
  input  logic      out_stall,
  output ghht_out_t out_data
);

  localparam int IDXW       = $clog2(CAPACITY);
  localparam int CNTW       = $clog2(CAPACITY + 1);
  localparam int LOAD_LIMIT = CAPACITY * 3 / 4;

  ghht_slot_t slot_mem [CAPACITY];

  logic [KEY_W-1:0]      key_r;
  logic [SLOT_NUM_W-1:0] hslot_r;
  logic [GEN_W-1:0]      hgen_r;
  logic [IDXW-1:0]       idx_r;
  logic [IDXW-1:0]       probe_cnt_r;
  logic [IDXW-1:0]       scan_r;
  logic [IDXW-1:0]       wb_addr_r;
  logic                  wb_v_r;
  logic [CNTW-1:0]       count_r;
  ghht_slot_t            rd_data_r;
  ghht_status_t          res_status_r;
  logic [SLOT_NUM_W-1:0] res_slot_r;
  logic [GEN_W-1:0]      res_gen_r;
  logic                  out_valid_r;
  ghht_out_t             out_data_r;

  logic [KEY_W-1:0]      tag_key;
  logic [IDXW-1:0]       mix_lo;
  logic [2*IDXW-1:0]     hash_prod;
  logic [IDXW-1:0]       check_addr;
  logic                  check_live;
  logic [SLOT_NUM_W-1:0] slot_num;
  logic                  freeing;
  logic                  rd_en;
  logic [IDXW-1:0]       rd_addr;
  logic                  wr_en;
  logic [IDXW-1:0]       wr_addr;
  ghht_slot_t            wr_data;
  logic                  cnt_inc;
  logic                  cnt_dec;

  // only the low index bits of the 2*IDXW-bit product matter
  assign tag_key   = {1'b1, key_r[KEY_W-2:0]};
  assign mix_lo    = tag_key[IDXW-1:0] ^ tag_key[IDXW+15:16];
  assign hash_prod = mix_lo * HASH_MUL[IDXW-1:0];

  assign check_addr = IDXW'(hslot_r - 9'd1);
  assign check_live = (hslot_r != '0) && (17'(hslot_r) <= 17'(CAPACITY))
                      && (rd_data_r.key != '0) && (rd_data_r.gen == hgen_r);
  assign slot_num   = SLOT_NUM_W'({1'b0, idx_r} + (IDXW+1)'(1));
  assign freeing    = (rd_data_r.key != '0) && !rd_data_r.touched;

  assign sts.hit        = (rd_data_r.key == tag_key);
  assign sts.empty      = (rd_data_r.key == '0);
  assign sts.load_full  = (count_r >= CNTW'(LOAD_LIMIT));
  assign sts.probe_last = (probe_cnt_r == '1);
  assign sts.scan_last  = (scan_r == '1);
  assign sts.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = idx_r;
    unique case (cmd.rd_kind)
      RD_NONE:  rd_en   = 1'b0;
      RD_PROBE: rd_addr = idx_r;
      RD_CHECK: rd_addr = check_addr;
      RD_SCAN:  rd_addr = scan_r;
      default:  rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = rd_data_r;
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    if (wb_v_r) begin
      // sweep writeback of the slot read last cycle
      wr_en           = 1'b1;
      wr_addr         = wb_addr_r;
      wr_data.touched = 1'b0;
      if (freeing) begin
        wr_data.key = '0;
        wr_data.gen = rd_data_r.gen + 32'd1;
        cnt_dec     = (count_r != '0);
      end
    end else begin
      unique case (cmd.wr_kind)
        WR_NONE: wr_en = 1'b0;
        WR_CLEAR: begin
          wr_en   = 1'b1;
          wr_addr = scan_r;
          wr_data = '0;
        end
        WR_TOUCH: begin
          wr_en           = 1'b1;
          wr_data.touched = 1'b1;
        end
        WR_INSERT: begin
          wr_en           = 1'b1;
          wr_data.key     = tag_key;
          wr_data.touched = 1'b1;
          cnt_inc         = 1'b1;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) slot_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= slot_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key_r   <= in_data.key;
      hslot_r <= in_data.handle_slot;
      hgen_r  <= in_data.handle_generation;
    end
    if (cmd.hash_en) begin
      idx_r       <= hash_prod[IDXW-1:0];
      probe_cnt_r <= '0;
    end else if (cmd.probe_step) begin
      idx_r       <= idx_r + 1'b1;
      probe_cnt_r <= probe_cnt_r + 1'b1;
    end
    wb_addr_r <= scan_r;
    case (cmd.res_kind) inside
      RES_FOUND, RES_INSERTED: begin
        res_status_r <= (cmd.res_kind == RES_FOUND) ? STATUS_FOUND : STATUS_INSERTED;
        res_slot_r   <= slot_num;
        res_gen_r    <= rd_data_r.gen;
      end
      RES_NULL, RES_FULL, RES_SWEPT, RES_CHECK: begin
        res_slot_r <= '0;
        res_gen_r  <= '0;
        if (cmd.res_kind == RES_NULL)      res_status_r <= STATUS_NULL_KEY;
        else if (cmd.res_kind == RES_FULL) res_status_r <= STATUS_FULL;
        else if (cmd.res_kind == RES_CHECK && check_live) res_status_r <= STATUS_LIVE;
        else                               res_status_r <= STATUS_NOT_LIVE;
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_data_r.status          <= res_status_r;
      out_data_r.slot_number     <= res_slot_r;
      out_data_r.slot_generation <= res_gen_r;
      out_data_r.occupied_count  <= SLOT_NUM_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      wb_v_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.scan_inc) scan_r <= scan_r + 1'b1;
      wb_v_r <= (cmd.rd_kind == RD_SCAN);
      if (cnt_inc)      count_r <= count_r + 1'b1;
      else if (cnt_dec) count_r <= count_r - 1'b1;
      if (cmd.out_load)    out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
